// File: src/bstk_pkg.sv
// Shared codes, widths and types for the bounded stack.
`default_nettype none

package bstk_pkg;

    // Build defaults
    localparam int DEPTH_DEF      = 64;
    localparam int VALUE_BITS_DEF = 64;

    // Fixed field widths
    localparam int MODE_BITS   = 3;
    localparam int FLAG_BITS   = 2;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 7;
    localparam int PORT_BITS   = 64;

    localparam logic [COUNT_BITS-1:0] CAP_RESET = 7'd64;

    // Request kinds
    localparam logic [MODE_BITS-1:0] MODE_PUSH_CHK = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_PUSH     = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_POP      = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_PEEK     = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_DROP     = 3'd4;

    // Push flags
    localparam logic [FLAG_BITS-1:0] FLAG_ANY   = 2'd0;
    localparam logic [FLAG_BITS-1:0] FLAG_EXIST = 2'd2;

    // Result status
    localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_INVALID = 2'd3;

    // Storage access for one word
    typedef struct packed {
        logic wr;   // push writes the new top slot
        logic rd;   // pop/peek read the top slot
    } bstk_op_t;

endpackage

`default_nettype wire

// File: src/bstk_mem.sv
// Entry storage: one write port, one registered read port that returns zero on a non-reading request.
`default_nettype none

module bstk_mem #(
    parameter int DEPTH      = bstk_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = bstk_pkg::VALUE_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     go,
    input  wire bstk_pkg::bstk_op_t       op,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [VALUE_BITS-1:0]    wdata,
    output logic      [VALUE_BITS-1:0]    rdata
);

    logic [VALUE_BITS-1:0] mem [DEPTH];
    logic [VALUE_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (go && op.wr)
        begin
            mem[addr] <= wdata;
        end
    end

    // read register doubles as the result's value field
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rdata_reg <= op.rd ? mem[addr] : '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: src/bstk_ctrl.sv
// Ring pointer, count and capacity: decides each request and its storage access.
`default_nettype none

module bstk_ctrl #(
    parameter int DEPTH = bstk_pkg::DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [bstk_pkg::COUNT_BITS-1:0]     cfg_data,
    input  wire logic                                go,
    input  wire logic [bstk_pkg::MODE_BITS-1:0]      mode,
    input  wire logic [bstk_pkg::FLAG_BITS-1:0]      push_flags,
    output logic      [bstk_pkg::STATUS_BITS-1:0]    status,
    output logic      [bstk_pkg::COUNT_BITS-1:0]     entry_count,
    output bstk_pkg::bstk_op_t                       op,
    output logic      [$clog2(DEPTH)-1:0]            addr
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FULL_W = $clog2(DEPTH + 1);
    localparam int CNT_W  = (FULL_W < bstk_pkg::COUNT_BITS) ? FULL_W : bstk_pkg::COUNT_BITS;
    localparam int SUM_W  = $clog2(2 * DEPTH);

    logic [bstk_pkg::COUNT_BITS-1:0] capacity_reg;
    logic [PTR_W-1:0]                bottom_reg;
    logic [PTR_W-1:0]                bottom_next;
    logic [CNT_W-1:0]                count_reg;
    logic [CNT_W-1:0]                count_next;
    logic [CNT_W-1:0]                eff_cap;
    logic [SUM_W-1:0]                push_sum;
    logic [SUM_W-1:0]                top_sum;
    logic [SUM_W-1:0]                bump_sum;
    logic [PTR_W-1:0]                push_slot;
    logic [PTR_W-1:0]                top_slot;
    logic [PTR_W-1:0]                bottom_bump;
    logic                            full;
    logic                            empty;
    logic                            do_push;

    // capacity clamped to 1..DEPTH
    always_comb
    begin
        priority if (capacity_reg == '0)
            eff_cap = CNT_W'(1);
        else if (32'(capacity_reg) > DEPTH)
            eff_cap = CNT_W'(DEPTH);
        else
            eff_cap = CNT_W'(capacity_reg);
    end

    assign full  = (count_reg >= eff_cap);
    assign empty = (count_reg == '0);

    // ring slots: sums stay below 2*DEPTH, so one conditional subtract wraps them
    assign push_sum = SUM_W'(bottom_reg) + SUM_W'(count_reg);
    assign top_sum  = SUM_W'(bottom_reg) + SUM_W'(count_reg - CNT_W'(1));
    assign bump_sum = SUM_W'(bottom_reg) + SUM_W'(1);

    assign push_slot   = PTR_W'((push_sum >= SUM_W'(DEPTH)) ? push_sum - SUM_W'(DEPTH) : push_sum);
    assign top_slot    = PTR_W'((top_sum >= SUM_W'(DEPTH)) ? top_sum - SUM_W'(DEPTH) : top_sum);
    assign bottom_bump = PTR_W'((bump_sum >= SUM_W'(DEPTH)) ? bump_sum - SUM_W'(DEPTH) : bump_sum);

    always_comb
    begin
        status      = bstk_pkg::ST_OK;
        op          = '0;
        addr        = top_slot;
        bottom_next = bottom_reg;
        count_next  = count_reg;
        do_push     = 1'b0;

        unique case (mode)
            bstk_pkg::MODE_PUSH_CHK:
            begin
                if (push_flags != bstk_pkg::FLAG_ANY && push_flags != bstk_pkg::FLAG_EXIST)
                    status = bstk_pkg::ST_INVALID;
                else
                    do_push = 1'b1;
            end
            bstk_pkg::MODE_PUSH:
            begin
                do_push = 1'b1;
            end
            bstk_pkg::MODE_POP, bstk_pkg::MODE_PEEK, bstk_pkg::MODE_DROP:
            begin
                if (empty)
                begin
                    status = bstk_pkg::ST_EMPTY;
                end
                else
                begin
                    op.rd = (mode != bstk_pkg::MODE_DROP);
                    if (mode != bstk_pkg::MODE_PEEK)
                        count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status = bstk_pkg::ST_INVALID;
            end
        endcase

        // new top always lands at bottom+count; on eviction the count holds
        if (do_push)
        begin
            addr = push_slot;
            if (full && push_flags != bstk_pkg::FLAG_EXIST)
            begin
                status = bstk_pkg::ST_FULL;
            end
            else
            begin
                op.wr = 1'b1;
                if (full)
                    bottom_next = bottom_bump;
                else
                    count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= bstk_pkg::CAP_RESET;
            bottom_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                capacity_reg <= cfg_data;
            if (go)
            begin
                bottom_reg <= bottom_next;
                count_reg  <= count_next;
            end
        end
    end

    assign entry_count = bstk_pkg::COUNT_BITS'(count_next);

endmodule

`default_nettype wire

// File: src/bounded_stack_with_evict_oldest.sv
// Top level of the bounded stack that evicts its oldest entry when full.
//
// Request channel (req_valid / req_stall) carries one word: mode, push_flags,
// push_value. Response channel (rsp_valid / rsp_stall) returns one word per
// request: status, read_value, entry_count. A word moves on a rising edge with
// valid high and stall low.
// An accepted request is held in the request register until the response slot is free;
// it is then decided and applied, and its response is offered from the response register.
// Throughput: one request per clock while the response is not stalled; the ring pointer,
// count and storage access all complete in that single step. The storage read is
// registered and forms the response value directly.
// Capacity is to be written by the user through cfg_we / cfg_data only while the
// block is idle; the block does not enforce it. Reset (rst_n, async low) empties
// the stack, zeroes the bottom pointer, restores capacity to 64; storage is not cleared.
// A stalled response holds; the request register still takes one more word,
// after which req_stall rises until the response moves.
`default_nettype none

module bounded_stack_with_evict_oldest #(
    parameter int DEPTH      = bstk_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = bstk_pkg::VALUE_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration
    input  wire logic                               cfg_we,
    input  wire logic [bstk_pkg::COUNT_BITS-1:0]    cfg_data,
    // request channel
    input  wire logic                               req_valid,
    output logic                                    req_stall,
    input  wire logic [bstk_pkg::MODE_BITS-1:0]     mode,
    input  wire logic [bstk_pkg::FLAG_BITS-1:0]     push_flags,
    input  wire logic [bstk_pkg::PORT_BITS-1:0]     push_value,
    // response channel
    output logic                                    rsp_valid,
    input  wire logic                               rsp_stall,
    output logic      [bstk_pkg::STATUS_BITS-1:0]   status,
    output logic      [bstk_pkg::PORT_BITS-1:0]     read_value,
    output logic      [bstk_pkg::COUNT_BITS-1:0]    entry_count
);

    localparam int PTR_W = $clog2(DEPTH);

    // request register
    logic                             req_valid_reg;
    logic                             req_valid_next;
    logic [bstk_pkg::MODE_BITS-1:0]   mode_reg;
    logic [bstk_pkg::FLAG_BITS-1:0]   flags_reg;
    logic [VALUE_BITS-1:0]            value_reg;

    // response register (value part lives in the storage read register)
    logic                             rsp_valid_reg;
    logic                             rsp_valid_next;
    logic [bstk_pkg::STATUS_BITS-1:0] status_reg;
    logic [bstk_pkg::COUNT_BITS-1:0]  count_out_reg;

    logic                             rsp_free;
    logic                             go;
    logic                             req_take;
    logic [bstk_pkg::STATUS_BITS-1:0] dec_status;
    logic [bstk_pkg::COUNT_BITS-1:0]  dec_count;
    bstk_pkg::bstk_op_t               dec_op;
    logic [PTR_W-1:0]                 dec_addr;
    logic [VALUE_BITS-1:0]            rd_data;

    // response slot is free when empty or being taken this cycle
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign go        = req_valid_reg && rsp_free;
    assign req_stall = req_valid_reg && !rsp_free;
    assign req_take  = req_valid && !req_stall;

    assign req_valid_next = req_take || (req_valid_reg && !go);
    assign rsp_valid_next = go || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            mode_reg  <= mode;
            flags_reg <= push_flags;
            value_reg <= push_value[VALUE_BITS-1:0];
        end
        if (go)
        begin
            status_reg    <= dec_status;
            count_out_reg <= dec_count;
        end
    end

    bstk_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .go          (go),
        .mode        (mode_reg),
        .push_flags  (flags_reg),
        .status      (dec_status),
        .entry_count (dec_count),
        .op          (dec_op),
        .addr        (dec_addr)
    );

    bstk_mem #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_mem (
        .clk   (clk),
        .go    (go),
        .op    (dec_op),
        .addr  (dec_addr),
        .wdata (value_reg),
        .rdata (rd_data)
    );

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign entry_count = count_out_reg;
    assign read_value  = bstk_pkg::PORT_BITS'(rd_data);

    // count reported never exceeds the built depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(entry_count) <= DEPTH))
        else $error("entry_count above depth");

    // failed requests (empty, full or invalid status) return a zero value
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == bstk_pkg::ST_EMPTY || status == bstk_pkg::ST_FULL
                       || status == bstk_pkg::ST_INVALID)) |-> (read_value == '0))
        else $error("nonzero value on failed request");

    // a full response means the stack was holding entries
    a_full_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == bstk_pkg::ST_FULL) |-> (entry_count != '0))
        else $error("full status with empty stack");

    // a taken response with nothing queued behind it leaves the slot empty
    a_rsp_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_stall && !req_valid_reg) |=> !rsp_valid)
        else $error("response repeated");

endmodule

`default_nettype wire
